### hdl/rkh_pkg.sv
package rkh_pkg;

    localparam int COUNT_BITS_DEF = 32;
    localparam int OUT_BITS       = 32;

    // count memories: 2-mer and 3-mer, each split as mate x side x k-mer
    localparam int DEPTH2  = 100;
    localparam int DEPTH3  = 500;
    localparam int A2_BITS = $clog2(DEPTH2);
    localparam int A3_BITS = $clog2(DEPTH3);

    localparam logic [A2_BITS-1:0] MATE2_OFS = A2_BITS'(50);
    localparam logic [A2_BITS-1:0] SIDE2_OFS = A2_BITS'(25);
    localparam logic [A3_BITS-1:0] MATE3_OFS = A3_BITS'(250);
    localparam logic [A3_BITS-1:0] SIDE3_OFS = A3_BITS'(125);

    localparam logic [6:0] IDX2_MAX = 7'd24;
    localparam logic [6:0] IDX3_MAX = 7'd124;

    localparam logic OP_BASE = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic KMER_2 = 1'b0;
    localparam logic KMER_3 = 1'b1;

    localparam logic KIND_COUNT  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [1:0] ST_FULL = 2'd0;
    localparam logic [1:0] ST_NO3  = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    localparam logic [2:0] BASE_N = 3'd4;

    // what a read end asks of the count memories
    typedef struct packed {
        logic       cnt2;
        logic       cnt3;
        logic [1:0] status;
        logic [4:0] fi2;
        logic [4:0] ri2;
        logic [6:0] fi3;
        logic [6:0] ri3;
    } t_end_info;

    typedef struct packed {
        logic                kind;
        logic [OUT_BITS-1:0] count;
        logic [1:0]          short_read;
    } t_result;

endpackage

### hdl/rkh_track.sv
module rkh_track
    import rkh_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic       i_mate,
    input  logic [2:0] i_base,
    input  logic       i_last_base,
    output t_end_info  o_end
);

    localparam logic [1:0] SEEN_MAX = 2'd3;

    logic [8:0] r_front [2];
    logic [8:0] r_rear  [2];
    logic [1:0] r_seen  [2];

    logic [2:0] w_code;
    logic [1:0] w_seen;
    logic [1:0] n_seen;
    logic [8:0] n_front;
    logic [8:0] n_rear;

    function automatic logic [4:0] f_idx2(input logic [2:0] c1, input logic [2:0] c0);
        f_idx2 = {c1, 2'b00} + {2'b00, c1} + {2'b00, c0};
    endfunction

    function automatic logic [6:0] f_idx3(input logic [2:0] c2, input logic [2:0] c1,
                                          input logic [2:0] c0);
        logic [4:0] hi;
        hi = f_idx2(c2, c1);
        f_idx3 = {hi, 2'b00} + {2'b00, hi} + {4'b0000, c0};
    endfunction

    always_comb begin
        w_code  = (i_base > BASE_N) ? BASE_N : i_base;
        w_seen  = r_seen[i_mate];
        n_seen  = (w_seen == SEEN_MAX) ? w_seen : w_seen + 2'd1;
        n_front = (w_seen == SEEN_MAX) ? r_front[i_mate] : {r_front[i_mate][5:0], w_code};
        n_rear  = {r_rear[i_mate][5:0], w_code};

        o_end.cnt2   = (n_seen >= 2'd2);
        o_end.cnt3   = (n_seen == SEEN_MAX);
        o_end.status = (n_seen == SEEN_MAX) ? ST_FULL : ((n_seen == 2'd2) ? ST_NO3 : ST_NONE);
        // the front 2-mer is the two oldest codes held
        o_end.fi2    = (n_seen == SEEN_MAX) ? f_idx2(n_front[8:6], n_front[5:3])
                                            : f_idx2(n_front[5:3], n_front[2:0]);
        o_end.ri2    = f_idx2(n_rear[5:3], n_rear[2:0]);
        o_end.fi3    = f_idx3(n_front[8:6], n_front[5:3], n_front[2:0]);
        o_end.ri3    = f_idx3(n_rear[8:6], n_rear[5:3], n_rear[2:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 2; i++) begin
                r_front[i] <= '0;
                r_rear[i]  <= '0;
                r_seen[i]  <= '0;
            end
        end else if (i_step) begin
            if (i_last_base) begin
                r_front[i_mate] <= '0;
                r_rear[i_mate]  <= '0;
                r_seen[i_mate]  <= '0;
            end else begin
                r_front[i_mate] <= n_front;
                r_rear[i_mate]  <= n_rear;
                r_seen[i_mate]  <= n_seen;
            end
        end
    end

endmodule

### hdl/read_end_kmer_histogram_core.sv
// End-of-read k-mer histogram. Bases and readout requests enter one per cycle
// while stall is low. For a base that ends a read of two or more bases, the
// front and rear k-mer counts go through the single write port of each count
// memory in turn, so input stall rises for one cycle after that request. Counts
// live in two memories (2-mer, 100 entries; 3-mer, 500 entries) updated by
// read-modify-write with forwarding of the last write. Results pass through the
// issue register and a two-entry output queue, in request order. After reset
// the memories are cleared in a pass over all 500 addresses during which stall
// stays high.
module read_end_kmer_histogram_core
    import rkh_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_op,
    input  logic                i_mate,
    input  logic [2:0]          i_base,
    input  logic                i_last_base,
    input  logic                i_end_side,
    input  logic                i_kmer_len,
    input  logic [6:0]          i_table_index,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_kind,
    output logic [OUT_BITS-1:0] o_count_value,
    output logic [1:0]          o_short_read
);

    logic [COUNT_BITS-1:0] r_mem2 [DEPTH2];
    logic [COUNT_BITS-1:0] r_mem3 [DEPTH3];
    logic [COUNT_BITS-1:0] r_rd2;
    logic [COUNT_BITS-1:0] r_rd3;

    logic               r_clr_busy;
    logic [A3_BITS-1:0] r_clr_addr;

    logic               r_rear_pend;
    logic [A2_BITS-1:0] r_rear_a2;
    logic [A3_BITS-1:0] r_rear_a3;
    logic               r_rear_we3;

    logic               r_s1_valid;
    logic               r_s1_res;
    logic               r_s1_kind;
    logic [1:0]         r_s1_short;
    logic               r_s1_k3;
    logic               r_s1_ok;
    logic               r_s1_we2;
    logic               r_s1_we3;
    logic [A2_BITS-1:0] r_s1_a2;
    logic [A3_BITS-1:0] r_s1_a3;

    logic               n_s1_valid;
    logic               n_s1_res;
    logic               n_s1_kind;
    logic [1:0]         n_s1_short;
    logic               n_s1_k3;
    logic               n_s1_ok;
    logic               n_s1_we2;
    logic               n_s1_we3;
    logic [A2_BITS-1:0] n_s1_a2;
    logic [A3_BITS-1:0] n_s1_a3;
    logic               n_rear_pend;

    logic                  r_fw2_valid;
    logic [A2_BITS-1:0]    r_fw2_addr;
    logic [COUNT_BITS-1:0] r_fw2_data;
    logic                  r_fw3_valid;
    logic [A3_BITS-1:0]    r_fw3_addr;
    logic [COUNT_BITS-1:0] r_fw3_data;

    t_result    r_q [2];
    logic       r_q_head;
    logic [1:0] r_q_cnt;

    logic                  w_acc;
    logic                  w_pop;
    logic                  w_push;
    logic [1:0]            w_occ;
    t_end_info             w_end;
    t_result               w_res;
    logic [A2_BITS-1:0]    w_mofs2;
    logic [A3_BITS-1:0]    w_mofs3;
    logic [A2_BITS-1:0]    w_fa2;
    logic [A2_BITS-1:0]    w_ra2;
    logic [A3_BITS-1:0]    w_fa3;
    logic [A3_BITS-1:0]    w_ra3;
    logic                  w_ro_ok;
    logic [A2_BITS-1:0]    w_ro_a2;
    logic [A3_BITS-1:0]    w_ro_a3;
    logic [COUNT_BITS-1:0] w_v2;
    logic [COUNT_BITS-1:0] w_v3;
    logic [COUNT_BITS-1:0] w_inc2;
    logic [COUNT_BITS-1:0] w_inc3;
    logic [COUNT_BITS-1:0] w_rv;
    logic [OUT_BITS-1:0]   w_rv32;
    logic                  w_s1_wr2;
    logic                  w_s1_wr3;
    logic                  w_we2;
    logic                  w_we3;
    logic [A2_BITS-1:0]    w_wa2;
    logic [A3_BITS-1:0]    w_wa3;
    logic [COUNT_BITS-1:0] w_wd2;
    logic [COUNT_BITS-1:0] w_wd3;

    rkh_track u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_acc && (i_op == OP_BASE)),
        .i_mate      (i_mate),
        .i_base      (i_base),
        .i_last_base (i_last_base),
        .o_end       (w_end)
    );

    // handshake
    assign w_acc   = i_valid && !o_stall;
    assign o_valid = (r_q_cnt != 2'd0);
    assign w_pop   = o_valid && !i_stall;
    assign w_push  = r_s1_valid && r_s1_res;
    // hold off unless the queue has room once the request now in flight lands
    assign w_occ   = r_q_cnt + {1'b0, w_push} - {1'b0, w_pop};
    assign o_stall = r_clr_busy || r_rear_pend || (w_occ >= 2'd2);

    // addresses
    assign w_mofs2 = i_mate ? MATE2_OFS : '0;
    assign w_mofs3 = i_mate ? MATE3_OFS : '0;
    assign w_fa2   = w_mofs2 + A2_BITS'(w_end.fi2);
    assign w_ra2   = w_mofs2 + SIDE2_OFS + A2_BITS'(w_end.ri2);
    assign w_fa3   = w_mofs3 + A3_BITS'(w_end.fi3);
    assign w_ra3   = w_mofs3 + SIDE3_OFS + A3_BITS'(w_end.ri3);

    assign w_ro_ok = (i_kmer_len == KMER_3) ? (i_table_index <= IDX3_MAX)
                                            : (i_table_index <= IDX2_MAX);
    assign w_ro_a2 = (w_ro_ok && (i_kmer_len == KMER_2))
                   ? w_mofs2 + (i_end_side ? SIDE2_OFS : '0) + A2_BITS'(i_table_index)
                   : '0;
    assign w_ro_a3 = (w_ro_ok && (i_kmer_len == KMER_3))
                   ? w_mofs3 + (i_end_side ? SIDE3_OFS : '0) + A3_BITS'(i_table_index)
                   : '0;

    // issue stage: pick the memory access for this cycle
    always_comb begin
        n_s1_valid  = 1'b0;
        n_s1_res    = 1'b0;
        n_s1_kind   = KIND_COUNT;
        n_s1_short  = ST_FULL;
        n_s1_k3     = i_kmer_len;
        n_s1_ok     = w_ro_ok;
        n_s1_we2    = 1'b0;
        n_s1_we3    = 1'b0;
        n_s1_a2     = '0;
        n_s1_a3     = '0;
        n_rear_pend = 1'b0;
        if (r_rear_pend) begin
            n_s1_valid = 1'b1;
            n_s1_we2   = 1'b1;
            n_s1_we3   = r_rear_we3;
            n_s1_a2    = r_rear_a2;
            n_s1_a3    = r_rear_a3;
        end else if (w_acc) begin
            if (i_op == OP_READ) begin
                n_s1_valid = 1'b1;
                n_s1_res   = 1'b1;
                n_s1_a2    = w_ro_a2;
                n_s1_a3    = w_ro_a3;
            end else if (i_last_base) begin
                n_s1_valid  = 1'b1;
                n_s1_res    = 1'b1;
                n_s1_kind   = KIND_STATUS;
                n_s1_short  = w_end.status;
                n_s1_we2    = w_end.cnt2;
                n_s1_we3    = w_end.cnt3;
                n_s1_a2     = w_end.cnt2 ? w_fa2 : '0;
                n_s1_a3     = w_end.cnt3 ? w_fa3 : '0;
                n_rear_pend = w_end.cnt2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rear_pend <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_s1_res    <= 1'b0;
        end else begin
            r_rear_pend <= n_rear_pend;
            r_s1_valid  <= n_s1_valid;
            r_s1_res    <= n_s1_res;
        end
        if (n_rear_pend) begin
            r_rear_a2  <= w_end.cnt2 ? w_ra2 : '0;
            r_rear_a3  <= w_end.cnt3 ? w_ra3 : '0;
            r_rear_we3 <= w_end.cnt3;
        end
        r_s1_kind  <= n_s1_kind;
        r_s1_short <= n_s1_short;
        r_s1_k3    <= n_s1_k3;
        r_s1_ok    <= n_s1_ok;
        r_s1_we2   <= n_s1_we2;
        r_s1_we3   <= n_s1_we3;
        r_s1_a2    <= n_s1_a2;
        r_s1_a3    <= n_s1_a3;
    end

    // clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == A3_BITS'(DEPTH3 - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + A3_BITS'(1);
        end
    end

    // modify: take the write of the previous cycle over the stale read
    assign w_v2     = (r_fw2_valid && (r_fw2_addr == r_s1_a2)) ? r_fw2_data : r_rd2;
    assign w_v3     = (r_fw3_valid && (r_fw3_addr == r_s1_a3)) ? r_fw3_data : r_rd3;
    assign w_inc2   = (&w_v2) ? w_v2 : w_v2 + COUNT_BITS'(1);
    assign w_inc3   = (&w_v3) ? w_v3 : w_v3 + COUNT_BITS'(1);
    assign w_s1_wr2 = r_s1_valid && r_s1_we2;
    assign w_s1_wr3 = r_s1_valid && r_s1_we3;

    assign w_we2 = r_clr_busy ? (r_clr_addr < A3_BITS'(DEPTH2)) : w_s1_wr2;
    assign w_we3 = r_clr_busy || w_s1_wr3;
    assign w_wa2 = r_clr_busy ? r_clr_addr[A2_BITS-1:0] : r_s1_a2;
    assign w_wa3 = r_clr_busy ? r_clr_addr : r_s1_a3;
    assign w_wd2 = r_clr_busy ? '0 : w_inc2;
    assign w_wd3 = r_clr_busy ? '0 : w_inc3;

    always_ff @(posedge i_clk) begin
        r_rd2 <= r_mem2[n_s1_a2];
        if (w_we2) begin
            r_mem2[w_wa2] <= w_wd2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd3 <= r_mem3[n_s1_a3];
        if (w_we3) begin
            r_mem3[w_wa3] <= w_wd3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw2_valid <= 1'b0;
            r_fw3_valid <= 1'b0;
        end else begin
            r_fw2_valid <= w_s1_wr2;
            r_fw3_valid <= w_s1_wr3;
        end
        r_fw2_addr <= r_s1_a2;
        r_fw2_data <= w_inc2;
        r_fw3_addr <= r_s1_a3;
        r_fw3_data <= w_inc3;
    end

    // readout value, clamped to the output width
    assign w_rv = r_s1_k3 ? w_v3 : w_v2;

    if (COUNT_BITS > OUT_BITS) begin : g_sat
        assign w_rv32 = (|w_rv[COUNT_BITS-1:OUT_BITS]) ? '1 : w_rv[OUT_BITS-1:0];
    end else begin : g_nosat
        assign w_rv32 = OUT_BITS'(w_rv);
    end

    always_comb begin
        w_res.kind       = r_s1_kind;
        w_res.count      = ((r_s1_kind == KIND_COUNT) && r_s1_ok) ? w_rv32 : '0;
        w_res.short_read = r_s1_short;
    end

    // output queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_head <= 1'b0;
            r_q_cnt  <= 2'd0;
        end else begin
            if (w_pop) begin
                r_q_head <= ~r_q_head;
            end
            r_q_cnt <= r_q_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
        if (w_push) begin
            r_q[r_q_head ^ r_q_cnt[0]] <= w_res;
        end
    end

    assign o_kind        = r_q[r_q_head].kind;
    assign o_count_value = r_q[r_q_head].count;
    assign o_short_read  = r_q[r_q_head].short_read;

`ifndef SYNTH
    a_q_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_q_cnt == 2'd2 && !w_pop) |-> !w_push)
        else $error("output queue overflow");

    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_cnt != 2'd3)
        else $error("output queue count out of range");

    a_rear_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rear_pend |=> (r_s1_valid && r_s1_we2 && !r_s1_res))
        else $error("rear update slot lost");

    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (!r_s1_valid && !r_rear_pend))
        else $error("count update during clearing pass");
`endif

endmodule

### tb/read_end_kmer_histogram_core_tb.sv
`timescale 1ns / 100ps

module read_end_kmer_histogram_core_tb;
    import rkh_pkg::*;

    // counters narrower than the default width
    localparam int          CNT_BITS     = 16;
    localparam logic [63:0] COUNT_LIMIT  = {64{1'b1}} >> (64 - CNT_BITS);
    localparam int          REPEAT_READS = 40;
    localparam int          DRAIN_LIMIT  = 100000;
    localparam int          PRINT_LIMIT  = 100;

    localparam logic MATE_DNA   = 1'b0;
    localparam logic MATE_RNA   = 1'b1;
    localparam logic SIDE_FRONT = 1'b0;
    localparam logic SIDE_REAR  = 1'b1;

    localparam logic [2:0] BASE_A    = 3'd0;
    localparam logic [2:0] BASE_G    = 3'd1;
    localparam logic [2:0] BASE_C    = 3'd2;
    localparam logic [2:0] BASE_T    = 3'd3;
    localparam logic [2:0] BASE_RAW5 = 3'd5;
    localparam logic [2:0] BASE_RAW7 = 3'd7;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic                i_op;
    logic                i_mate;
    logic [2:0]          i_base;
    logic                i_last_base;
    logic                i_end_side;
    logic                i_kmer_len;
    logic [6:0]          i_table_index;
    logic                o_valid;
    logic                i_stall;
    logic                o_kind;
    logic [OUT_BITS-1:0] o_count_value;
    logic [1:0]          o_short_read;

    // expected copy of the block state
    logic [8:0]  front_codes [2];
    logic [8:0]  rear_codes [2];
    logic [1:0]  read_len [2];
    logic [63:0] two_mer_hist [DEPTH2];
    logic [63:0] three_mer_hist [DEPTH3];

    t_result pending_responses [$];
    t_result head_resp;

    int error_count     = 0;
    int sender_idle_pct = 0;
    int stall_pct       = 0;
    int hold_off_left   = 0;

    read_end_kmer_histogram_core #(
        .COUNT_BITS(CNT_BITS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_mate        (i_mate),
        .i_base        (i_base),
        .i_last_base   (i_last_base),
        .i_end_side    (i_end_side),
        .i_kmer_len    (i_kmer_len),
        .i_table_index (i_table_index),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_count_value (o_count_value),
        .o_short_read  (o_short_read)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    initial begin
        #30_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        error_count++;
    endtask

    task automatic add_expected(input t_result resp);
        pending_responses = {pending_responses, resp};
    endtask

    function automatic int code_at_pos(input logic [8:0] codes, input int pos);
        return int'(codes[3*pos +: 3]);
    endfunction

    function automatic logic [63:0] bump_count(input logic [63:0] c);
        return (c < COUNT_LIMIT) ? c + 64'd1 : c;
    endfunction

    task automatic predict_histogram_response(input logic op, input logic mate,
            input logic [2:0] base_code, input logic is_last, input logic side,
            input logic klen, input logic [6:0] idx);
        t_result     resp;
        logic [63:0] cnt;
        logic [2:0]  code;
        int          m;
        int          s;
        int          n;
        int          fi;
        int          ri;
        m    = int'(mate);
        s    = int'(side);
        resp = '0;
        if (op == OP_READ) begin
            cnt = '0;
            if (klen == KMER_2) begin
                if (idx <= IDX2_MAX) cnt = two_mer_hist[m*50 + s*25 + int'(idx)];
            end else if (idx <= IDX3_MAX) begin
                cnt = three_mer_hist[m*250 + s*125 + int'(idx)];
            end
            resp.kind       = KIND_COUNT;
            resp.count      = (cnt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : cnt[31:0];
            resp.short_read = ST_FULL;
            add_expected(resp);
            return;
        end
        // codes above N count as N
        code = (base_code > BASE_N) ? BASE_N : base_code;
        if (read_len[m] < 2'd3) begin
            front_codes[m] = {front_codes[m][5:0], code};
            read_len[m]    = read_len[m] + 2'd1;
        end
        rear_codes[m] = {rear_codes[m][5:0], code};
        if (!is_last) return;

        n = int'(read_len[m]);
        if (n >= 2) begin
            if (n == 3) begin
                fi = code_at_pos(front_codes[m], 2) * 5 + code_at_pos(front_codes[m], 1);
            end else begin
                fi = code_at_pos(front_codes[m], 1) * 5 + code_at_pos(front_codes[m], 0);
            end
            ri = code_at_pos(rear_codes[m], 1) * 5 + code_at_pos(rear_codes[m], 0);
            two_mer_hist[m*50 + fi]      = bump_count(two_mer_hist[m*50 + fi]);
            two_mer_hist[m*50 + 25 + ri] = bump_count(two_mer_hist[m*50 + 25 + ri]);
        end
        if (n == 3) begin
            fi = (code_at_pos(front_codes[m], 2) * 5 + code_at_pos(front_codes[m], 1)) * 5
                 + code_at_pos(front_codes[m], 0);
            ri = (code_at_pos(rear_codes[m], 2) * 5 + code_at_pos(rear_codes[m], 1)) * 5
                 + code_at_pos(rear_codes[m], 0);
            three_mer_hist[m*250 + fi]       = bump_count(three_mer_hist[m*250 + fi]);
            three_mer_hist[m*250 + 125 + ri] = bump_count(three_mer_hist[m*250 + 125 + ri]);
        end
        resp.kind       = KIND_STATUS;
        resp.count      = '0;
        resp.short_read = (n == 3) ? ST_FULL : ((n == 2) ? ST_NO3 : ST_NONE);
        front_codes[m]  = '0;
        rear_codes[m]   = '0;
        read_len[m]     = '0;
        add_expected(resp);
    endtask

    // Offer one request and hold it until accepted; valid stays high on return.
    task automatic send_request(input logic op, input logic mate, input logic [2:0] base_code,
            input logic is_last, input logic side, input logic klen, input logic [6:0] idx);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_op          <= op;
        i_mate        <= mate;
        i_base        <= base_code;
        i_last_base   <= is_last;
        i_end_side    <= side;
        i_kmer_len    <= klen;
        i_table_index <= idx;
        do begin
            @(posedge i_clk);
        end while (o_stall !== 1'b0);
        predict_histogram_response(op, mate, base_code, is_last, side, klen, idx);
    endtask

    task automatic send_base(input logic mate, input logic [2:0] code, input logic is_last);
        send_request(OP_BASE, mate, code, is_last, 1'($urandom_range(1)),
                     1'($urandom_range(1)), 7'($urandom_range(127)));
    endtask

    task automatic send_readout(input logic mate, input logic side, input logic klen,
            input logic [6:0] idx);
        send_request(OP_READ, mate, 3'($urandom_range(7)), 1'($urandom_range(1)),
                     side, klen, idx);
    endtask

    // Drop valid and wait for every outstanding result.
    task automatic drain_responses;
        int waited;
        waited = 0;
        i_valid <= 1'b0;
        while (pending_responses.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    task automatic run_directed_checks;
        send_readout(MATE_DNA, SIDE_FRONT, KMER_2, 7'd0);
        send_readout(MATE_RNA, SIDE_REAR, KMER_3, 7'd124);
        send_base(MATE_DNA, BASE_N, 1'b1);
        send_base(MATE_RNA, BASE_G, 1'b0);
        send_base(MATE_RNA, BASE_T, 1'b1);
        send_base(MATE_DNA, BASE_RAW7, 1'b0);
        send_base(MATE_DNA, BASE_C, 1'b0);
        send_base(MATE_DNA, BASE_A, 1'b1);
        // long read with the other mate's bases interleaved
        send_base(MATE_RNA, BASE_A, 1'b0);
        send_base(MATE_DNA, BASE_T, 1'b0);
        send_base(MATE_RNA, BASE_G, 1'b0);
        send_base(MATE_RNA, BASE_C, 1'b0);
        send_base(MATE_RNA, BASE_RAW5, 1'b0);
        send_base(MATE_RNA, BASE_T, 1'b1);
        send_base(MATE_DNA, BASE_T, 1'b1);
        send_readout(MATE_DNA, SIDE_FRONT, KMER_3, 7'd110);
        send_readout(MATE_DNA, SIDE_FRONT, KMER_2, 7'd22);
        send_readout(MATE_DNA, SIDE_REAR, KMER_2, 7'd10);
        send_readout(MATE_RNA, SIDE_FRONT, KMER_2, 7'd8);
        send_readout(MATE_RNA, SIDE_REAR, KMER_3, 7'd73);
        send_readout(MATE_DNA, SIDE_FRONT, KMER_2, 7'd24);
        send_readout(MATE_DNA, SIDE_FRONT, KMER_2, 7'd25);
        send_readout(MATE_RNA, SIDE_REAR, KMER_2, 7'd127);
        send_readout(MATE_DNA, SIDE_REAR, KMER_3, 7'd125);
        send_readout(MATE_RNA, SIDE_FRONT, KMER_3, 7'd127);
        drain_responses();
    endtask

    task automatic run_random_requests(input int n_items);
        int         k;
        logic       klen;
        logic [6:0] idx;
        logic [2:0] code;
        for (k = 0; k < n_items; k++) begin
            if ($urandom_range(99) < 20) begin
                klen = 1'($urandom_range(1));
                if (klen == KMER_2) begin
                    idx = ($urandom_range(99) < 85) ? 7'($urandom_range(24))
                                                    : 7'($urandom_range(127, 25));
                end else begin
                    idx = ($urandom_range(99) < 90) ? 7'($urandom_range(124))
                                                    : 7'($urandom_range(127, 125));
                end
                send_readout(1'($urandom_range(1)), 1'($urandom_range(1)), klen, idx);
            end else begin
                code = ($urandom_range(99) < 90) ? 3'($urandom_range(4))
                                                 : 3'($urandom_range(7, 5));
                send_base(1'($urandom_range(1)), code, $urandom_range(99) < 30);
            end
        end
    endtask

    task automatic run_idling_phase(input int send_pct, input int recv_pct, input int n_items);
        sender_idle_pct = send_pct;
        stall_pct       = recv_pct;
        run_random_requests(n_items);
        drain_responses();
    endtask

    // Hold the output long enough that the block backs up and stalls its input.
    task automatic run_output_hold_off;
        sender_idle_pct = 0;
        stall_pct       = 0;
        hold_off_left   = 300;
        run_random_requests(80);
        drain_responses();
    endtask

    // Same read over and over, back to back, so the same entries are updated repeatedly.
    task automatic run_repeated_read;
        int k;
        sender_idle_pct = 0;
        stall_pct       = 0;
        for (k = 0; k < REPEAT_READS; k++) begin
            send_base(MATE_RNA, BASE_T, 1'b0);
            send_base(MATE_RNA, BASE_T, 1'b0);
            send_base(MATE_RNA, BASE_T, 1'b1);
        end
        send_readout(MATE_RNA, SIDE_FRONT, KMER_2, 7'd18);
        send_readout(MATE_RNA, SIDE_REAR, KMER_2, 7'd18);
        send_readout(MATE_RNA, SIDE_FRONT, KMER_3, 7'd93);
        send_readout(MATE_RNA, SIDE_REAR, KMER_3, 7'd93);
        send_readout(MATE_RNA, SIDE_REAR, KMER_3, 7'd92);
        drain_responses();
    endtask

    always @(posedge i_clk) begin
        if (hold_off_left > 0) begin
            i_stall <= 1'b1;
            hold_off_left = hold_off_left - 1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_responses.size() == 0) begin
                report_mismatch("result with none expected");
            end else begin
                head_resp = pending_responses.pop_front();
                if (o_kind !== head_resp.kind)
                    report_mismatch($sformatf("kind %0b, expected %0b",
                                              o_kind, head_resp.kind));
                if (o_count_value !== head_resp.count)
                    report_mismatch($sformatf("count_value %0d, expected %0d",
                                              o_count_value, head_resp.count));
                if (o_short_read !== head_resp.short_read)
                    report_mismatch($sformatf("short_read %0d, expected %0d",
                                              o_short_read, head_resp.short_read));
            end
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_stall       <= 1'b0;
        i_op          <= OP_BASE;
        i_mate        <= MATE_DNA;
        i_base        <= BASE_A;
        i_last_base   <= 1'b0;
        i_end_side    <= SIDE_FRONT;
        i_kmer_len    <= KMER_2;
        i_table_index <= '0;
        foreach (front_codes[m]) begin
            front_codes[m] = '0;
            rear_codes[m]  = '0;
            read_len[m]    = '0;
        end
        foreach (two_mer_hist[a]) two_mer_hist[a] = '0;
        foreach (three_mer_hist[a]) three_mer_hist[a] = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed_checks();
        run_idling_phase(0, 0, 450);
        run_idling_phase(83, 0, 450);
        run_idling_phase(0, 83, 450);
        run_idling_phase(9, 9, 450);
        run_output_hold_off();
        run_repeated_read();

        drain_responses();
        repeat (10) @(posedge i_clk);
        if (pending_responses.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_responses.size()));
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
